// ===== hw/rtl/atwd_pkg.sv =====
// Shared types, codes and kernel constants of the a trous wavelet decomposition block.
package atwd_pkg;

   // Field and port widths fixed by the block's interface.
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 2;
   localparam int POS_W      = 6;
   localparam int PLANE_W    = 3;
   localparam int STATUS_W   = 2;
   localparam int SIZE_REG_W = 7;
   localparam int SCL_REG_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // The 2-D weight is at most 36, and a 25-tap sum of Q16.16 words stays below 2^40.
   localparam int WGT_W   = 6;
   localparam int ACC_W   = 41;
   localparam int TAP_W   = 3;
   localparam int PROD_W  = DATA_W + WGT_W + 1;

   localparam logic [TAP_W-1:0] TAP_FIRST = 3'd0;
   localparam logic [TAP_W-1:0] TAP_MID   = 3'd2;
   localparam logic [TAP_W-1:0] TAP_LAST  = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0]  CSR_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0]  CSR_COLS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0]  CSR_SCALES = 2'd2;
   localparam logic [SIZE_REG_W-1:0] ROWS_RST   = 7'd64;
   localparam logic [SIZE_REG_W-1:0] COLS_RST   = 7'd64;
   localparam logic [SCL_REG_W-1:0]  SCALES_RST = 3'd4;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_RUN  = 2'd1,
      CMD_READ = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_RANGE  = 2'd1,
      STAT_NO_RUN = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_READ  = 2'd1,
      ST_SWEEP = 2'd2,
      ST_DRAIN = 2'd3
   } state_type;

   // Which memory feeds the shared read word.
   typedef enum logic [1:0] {
      RD_SOURCE  = 2'd0,
      RD_SMOOTH0 = 2'd1,
      RD_SMOOTH1 = 2'd2,
      RD_DETAIL  = 2'd3
   } rd_src_type;

   // One-dimensional B3-spline tap: 1, 4, 6, 4, 1.
   function automatic logic [TAP_W-1:0] tap_coef(input logic [TAP_W-1:0] idx);
      logic [TAP_W-1:0] c;
      unique case (idx)
         3'd0, 3'd4: c = 3'd1;
         3'd1, 3'd3: c = 3'd4;
         3'd2:       c = 3'd6;
         default:    c = 3'd0;
      endcase
      return c;
   endfunction

   // Two-dimensional weight of tap (m, n), numerator over 256.
   function automatic logic [WGT_W-1:0] tap_weight(input logic [TAP_W-1:0] m,
                                                    input logic [TAP_W-1:0] n);
      logic [WGT_W-1:0] w;
      w = WGT_W'(tap_coef(m)) * WGT_W'(tap_coef(n));
      return w;
   endfunction

endpackage

// ===== hw/rtl/a_trous_wavelet_decompose_top.sv =====
// Top level of the a trous B3-spline wavelet decomposition block.
//
// Commands enter on the req_ ports and are taken at a clock edge where start is
// high and busy is low. Every command gives exactly one result on the rsp_
// ports, shown for one cycle with rsp_strobe; the receiver has no way to stall.
// Load writes one pixel and answers in the next cycle with busy staying low, so
// loads run at one per cycle. Read raises busy for its read state and answers
// from the registered memory word through the response register; an invalid
// read answers in the next cycle. Run walks every plane through one shared
// multiply-accumulate unit fed by one read port of the working plane, one kernel
// tap per cycle while a plane sweeps, and the result follows the last scale.
// Configuration writes on the csr_ port are always taken; sizes are latched at
// the start of a run and reads use the latched values. Reset loads the size
// registers with 64, 64 and 4 and marks the results as stale; the pixel and
// plane memories are not cleared and need no clearing pass.
module a_trous_wavelet_decompose_top #(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int MAX_SCALES = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [atwd_pkg::CMD_W-1:0]             req_cmd,
   input  logic [atwd_pkg::POS_W-1:0]             req_row,
   input  logic [atwd_pkg::POS_W-1:0]             req_col,
   input  logic [atwd_pkg::PLANE_W-1:0]           req_plane,
   input  logic signed [atwd_pkg::DATA_W-1:0]     req_pixel_value,
   output logic                                   rsp_strobe,
   output logic signed [atwd_pkg::DATA_W-1:0]     rsp_coefficient,
   output logic [atwd_pkg::STATUS_W-1:0]          rsp_status,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [atwd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [atwd_pkg::CSR_DATA_W-1:0]        csr_data
);
   import atwd_pkg::*;

   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W    = $clog2(MAX_COLS + 1);
   localparam int PIXA_W    = ROW_W + COL_W;
   localparam int PIX_DEPTH = 1 << PIXA_W;
   localparam int SCL_W     = (MAX_SCALES > 1) ? $clog2(MAX_SCALES) : 1;
   localparam int SCNT_W    = $clog2(MAX_SCALES + 1);
   localparam int DET_DEPTH = MAX_SCALES * PIX_DEPTH;
   localparam int DET_AW    = $clog2(DET_DEPTH);
   localparam int WRAP_W    = ((RCNT_W > CCNT_W) ? RCNT_W : CCNT_W) + 1;
   localparam int CMPR_W    = (RCNT_W > SIZE_REG_W) ? RCNT_W : SIZE_REG_W;
   localparam int CMPC_W    = (CCNT_W > SIZE_REG_W) ? CCNT_W : SIZE_REG_W;
   localparam int CMPS_W    = (SCNT_W > PLANE_W) ? SCNT_W : PLANE_W;
   localparam int RST_ROWS   = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int RST_COLS   = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int RST_SCALES = (MAX_SCALES < 4) ? MAX_SCALES : 4;

   // Tag that travels with each tap through the read, multiply and add stages.
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic               center;
      logic [WGT_W-1:0]   weight;
      logic [SCL_W-1:0]   scale;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
   } tap_tag_type;

   // Size clamping: zero counts as one, and anything above the maximum as the maximum.
   function automatic logic [RCNT_W-1:0] clamp_rows(input logic [SIZE_REG_W-1:0] v);
      logic [CMPR_W-1:0] ext;
      ext = CMPR_W'(v);
      if (ext == '0) return RCNT_W'(1);
      else if (ext > CMPR_W'(MAX_ROWS)) return RCNT_W'(MAX_ROWS);
      else return RCNT_W'(ext);
   endfunction

   function automatic logic [CCNT_W-1:0] clamp_cols(input logic [SIZE_REG_W-1:0] v);
      logic [CMPC_W-1:0] ext;
      ext = CMPC_W'(v);
      if (ext == '0) return CCNT_W'(1);
      else if (ext > CMPC_W'(MAX_COLS)) return CCNT_W'(MAX_COLS);
      else return CCNT_W'(ext);
   endfunction

   function automatic logic [SCNT_W-1:0] clamp_scales(input logic [SCL_REG_W-1:0] v);
      logic [CMPS_W-1:0] ext;
      ext = CMPS_W'(v);
      if (ext == '0) return SCNT_W'(1);
      else if (ext > CMPS_W'(MAX_SCALES)) return SCNT_W'(MAX_SCALES);
      else return SCNT_W'(ext);
   endfunction

   // Periodic wrap of pos +/- off where both are already below n.
   function automatic logic [WRAP_W-1:0] wrap_pos(input logic [WRAP_W-1:0] pos,
                                                  input logic [WRAP_W-1:0] off,
                                                  input logic [WRAP_W-1:0] n,
                                                  input logic              sub);
      logic [WRAP_W-1:0] t;
      if (sub) begin
         t = pos - off;
         if (t[WRAP_W-1]) t = t + n;
      end else begin
         t = pos + off;
         if (t >= n) t = t - n;
      end
      return t;
   endfunction

   // Doubling modulo n for a value already below n.
   function automatic logic [WRAP_W-1:0] dbl_mod(input logic [WRAP_W-1:0] x,
                                                 input logic [WRAP_W-1:0] n);
      logic [WRAP_W-1:0] t;
      t = x << 1;
      if (t >= n) t = t - n;
      return t;
   endfunction

   // Control state.
   state_type          state_ff, state_in;
   logic [SIZE_REG_W-1:0] cfg_rows_ff, cfg_rows_in;
   logic [SIZE_REG_W-1:0] cfg_cols_ff, cfg_cols_in;
   logic [SCL_REG_W-1:0]  cfg_scales_ff, cfg_scales_in;
   logic               results_valid_ff, results_valid_in;
   logic [RCNT_W-1:0]  run_rows_ff, run_rows_in;
   logic [CCNT_W-1:0]  run_cols_ff, run_cols_in;
   logic [SCNT_W-1:0]  run_scales_ff, run_scales_in;
   logic [RCNT_W-1:0]  row_o1_ff, row_o1_in, row_o2_ff, row_o2_in;
   logic [CCNT_W-1:0]  col_o1_ff, col_o1_in, col_o2_ff, col_o2_in;
   logic [SCL_W-1:0]   scale_ff, scale_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [TAP_W-1:0]   tm_ff, tm_in, tn_ff, tn_in;
   tap_tag_type        p1_ff, p1_in, p2_ff, fin_ff, fin_in;
   rd_src_type         rd_src_ff, rd_src_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;

   // Payload registers.
   logic signed [DATA_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [DATA_W-1:0] center_ff;
   logic signed [ACC_W-1:0]  fin_sum_ff;

   // Memories and their registered read words.
   logic signed [DATA_W-1:0] source_mem  [PIX_DEPTH];
   logic signed [DATA_W-1:0] smooth0_mem [PIX_DEPTH];
   logic signed [DATA_W-1:0] smooth1_mem [PIX_DEPTH];
   logic signed [DATA_W-1:0] detail_mem  [DET_DEPTH];
   logic signed [DATA_W-1:0] src_rd_ff, sm0_rd_ff, sm1_rd_ff, det_rd_ff;

   // Decoded control.
   logic                accept, issue_en, read_out, pipe_empty, drain_done;
   logic                load_ok, read_in_range, read_final, read_ok;
   logic                tap_done, col_end, row_end, sweep_end, last_scale;
   logic [RCNT_W-1:0]   cur_rows;
   logic [CCNT_W-1:0]   cur_cols;
   logic [SCNT_W-1:0]   cur_scales;
   logic [RCNT_W-1:0]   roff;
   logic [CCNT_W-1:0]   coff;
   logic                rsub, csub;
   logic [ROW_W-1:0]    issue_row;
   logic [COL_W-1:0]    issue_col;
   logic [PIXA_W-1:0]   mem_pix_addr, fin_pix_addr;
   logic [DET_AW-1:0]   det_raddr, det_waddr;
   logic                src_we, det_re;
   logic signed [DATA_W-1:0] rd_word, fin_smooth, fin_detail;
   logic signed [DATA_W:0]   fin_diff;

   assign csr_ready       = 1'b1;
   assign accept          = start && !busy;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_coefficient = rsp_coef_ff;

   // Sizes in use by loads and by the next run.
   assign cur_rows   = clamp_rows(cfg_rows_ff);
   assign cur_cols   = clamp_cols(cfg_cols_ff);
   assign cur_scales = clamp_scales(cfg_scales_ff);

   // Range checks of the command fields.
   assign load_ok = (CMPR_W'(req_row) < CMPR_W'(cur_rows)) &&
                    (CMPC_W'(req_col) < CMPC_W'(cur_cols));
   assign read_in_range = (CMPR_W'(req_row) < CMPR_W'(run_rows_ff)) &&
                          (CMPC_W'(req_col) < CMPC_W'(run_cols_ff)) &&
                          (CMPS_W'(req_plane) <= CMPS_W'(run_scales_ff));
   assign read_final = (CMPS_W'(req_plane) == CMPS_W'(run_scales_ff));
   assign read_ok    = results_valid_ff && read_in_range;

   // Sweep position: last tap of a pixel, of a row, of a plane.
   assign tap_done   = (tm_ff == TAP_LAST) && (tn_ff == TAP_LAST);
   assign col_end    = ((CCNT_W'(col_ff) + CCNT_W'(1)) == run_cols_ff);
   assign row_end    = ((RCNT_W'(row_ff) + RCNT_W'(1)) == run_rows_ff);
   assign sweep_end  = issue_en && tap_done && col_end && row_end;
   assign last_scale = ((SCNT_W'(scale_ff) + SCNT_W'(1)) == run_scales_ff);
   assign pipe_empty = !p1_ff.valid && !p2_ff.valid && !fin_ff.valid;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_RUN)) state_in = ST_SWEEP;
            else if (accept && (req_cmd == CMD_READ) && read_ok) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_IDLE;
         ST_SWEEP: if (sweep_end) state_in = ST_DRAIN;
         ST_DRAIN: if (pipe_empty) state_in = last_scale ? ST_IDLE : ST_SWEEP;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      issue_en   = (state_ff == ST_SWEEP);
      read_out   = (state_ff == ST_READ);
      drain_done = (state_ff == ST_DRAIN) && pipe_empty;
   end

   // Tap offsets: rows and columns wrap with the offsets of the current spacing.
   always_comb begin
      unique case (tm_ff)
         3'd0:    begin roff = row_o2_ff; rsub = 1'b1; end
         3'd1:    begin roff = row_o1_ff; rsub = 1'b1; end
         3'd3:    begin roff = row_o1_ff; rsub = 1'b0; end
         3'd4:    begin roff = row_o2_ff; rsub = 1'b0; end
         default: begin roff = '0;        rsub = 1'b0; end
      endcase
      unique case (tn_ff)
         3'd0:    begin coff = col_o2_ff; csub = 1'b1; end
         3'd1:    begin coff = col_o1_ff; csub = 1'b1; end
         3'd3:    begin coff = col_o1_ff; csub = 1'b0; end
         3'd4:    begin coff = col_o2_ff; csub = 1'b0; end
         default: begin coff = '0;        csub = 1'b0; end
      endcase
      issue_row = ROW_W'(wrap_pos(WRAP_W'(row_ff), WRAP_W'(roff), WRAP_W'(run_rows_ff), rsub));
      issue_col = COL_W'(wrap_pos(WRAP_W'(col_ff), WRAP_W'(coff), WRAP_W'(run_cols_ff), csub));
   end

   // Memory addresses: the sweep owns the pixel read port while it issues taps, the command fields otherwise.
   assign mem_pix_addr = issue_en ? {issue_row, issue_col}
                                  : {ROW_W'(req_row), COL_W'(req_col)};
   assign det_raddr    = DET_AW'({SCL_W'(req_plane), ROW_W'(req_row), COL_W'(req_col)});
   assign fin_pix_addr = {fin_ff.row, fin_ff.col};
   assign det_waddr    = DET_AW'({fin_ff.scale, fin_ff.row, fin_ff.col});
   assign src_we       = accept && (req_cmd == CMD_LOAD) && load_ok;
   assign det_re       = accept && (req_cmd == CMD_READ) && read_ok && !read_final;

   // Shared read word.
   always_comb begin
      unique case (rd_src_ff)
         RD_SOURCE:  rd_word = src_rd_ff;
         RD_SMOOTH0: rd_word = sm0_rd_ff;
         RD_SMOOTH1: rd_word = sm1_rd_ff;
         RD_DETAIL:  rd_word = det_rd_ff;
         default:    rd_word = src_rd_ff;
      endcase
   end

   // Tap stages: read, multiply by the weight, accumulate.
   always_comb begin
      p1_in.valid  = issue_en;
      p1_in.first  = (tm_ff == TAP_FIRST) && (tn_ff == TAP_FIRST);
      p1_in.last   = tap_done;
      p1_in.center = (tm_ff == TAP_MID) && (tn_ff == TAP_MID);
      p1_in.weight = tap_weight(tm_ff, tn_ff);
      p1_in.scale  = scale_ff;
      p1_in.row    = row_ff;
      p1_in.col    = col_ff;
      prod_in      = PROD_W'(rd_word * $signed({1'b0, p1_ff.weight}));
      acc_in       = p2_ff.first ? ACC_W'(prod_ff) : (acc_ff + ACC_W'(prod_ff));
      fin_in       = p2_ff;
      fin_in.valid = p2_ff.valid && p2_ff.last;
   end

   // Finish stage: floor of the sum over 256, then the saturated difference.
   always_comb begin
      fin_smooth = fin_sum_ff[DATA_W+7:8];
      fin_diff   = {center_ff[DATA_W-1], center_ff} - {fin_smooth[DATA_W-1], fin_smooth};
      if (fin_diff[DATA_W] != fin_diff[DATA_W-1]) begin
         fin_detail = fin_diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                       : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         fin_detail = fin_diff[DATA_W-1:0];
      end
   end

   // Next values of the configuration, run and response registers.
   always_comb begin
      cfg_rows_in      = cfg_rows_ff;
      cfg_cols_in      = cfg_cols_ff;
      cfg_scales_in    = cfg_scales_ff;
      results_valid_in = results_valid_ff;
      run_rows_in      = run_rows_ff;
      run_cols_in      = run_cols_ff;
      run_scales_in    = run_scales_ff;
      row_o1_in        = row_o1_ff;
      row_o2_in        = row_o2_ff;
      col_o1_in        = col_o1_ff;
      col_o2_in        = col_o2_ff;
      scale_in         = scale_ff;
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = STAT_OK;
      rsp_coef_in      = '0;

      // Configuration transfer.
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROWS:   cfg_rows_in   = csr_data;
            CSR_COLS:   cfg_cols_in   = csr_data;
            CSR_SCALES: cfg_scales_in = SCL_REG_W'(csr_data);
            default:    ;
         endcase
      end

      // Command transfer.
      if (accept) begin
         unique case (req_cmd)
            CMD_LOAD: begin
               rsp_strobe_in = 1'b1;
               if (load_ok) results_valid_in = 1'b0;
               else rsp_status_in = STAT_RANGE;
            end
            CMD_RUN: begin
               results_valid_in = 1'b0;
               run_rows_in      = cur_rows;
               run_cols_in      = cur_cols;
               run_scales_in    = cur_scales;
               row_o1_in        = (cur_rows == RCNT_W'(1)) ? '0 : RCNT_W'(1);
               col_o1_in        = (cur_cols == CCNT_W'(1)) ? '0 : CCNT_W'(1);
               row_o2_in        = RCNT_W'(dbl_mod(WRAP_W'(row_o1_in), WRAP_W'(cur_rows)));
               col_o2_in        = CCNT_W'(dbl_mod(WRAP_W'(col_o1_in), WRAP_W'(cur_cols)));
               scale_in         = '0;
            end
            CMD_READ: begin
               if (!results_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_NO_RUN;
               end else if (!read_in_range) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_RANGE;
               end
            end
            default: rsp_strobe_in = 1'b1;
         endcase
      end

      // Read data returns in the cycle after the memory read.
      if (read_out) begin
         rsp_strobe_in = 1'b1;
         rsp_coef_in   = rd_word;
      end

      // End of a plane: move to the next spacing or finish the run.
      if (drain_done) begin
         if (last_scale) begin
            results_valid_in = 1'b1;
            rsp_strobe_in    = 1'b1;
         end else begin
            scale_in  = scale_ff + SCL_W'(1);
            row_o1_in = row_o2_ff;
            col_o1_in = col_o2_ff;
            row_o2_in = RCNT_W'(dbl_mod(WRAP_W'(row_o2_ff), WRAP_W'(run_rows_ff)));
            col_o2_in = CCNT_W'(dbl_mod(WRAP_W'(col_o2_ff), WRAP_W'(run_cols_ff)));
         end
      end
   end

   // Sweep counters: tap column, tap row, pixel column, pixel row.
   always_comb begin
      tn_in = tn_ff;
      tm_in = tm_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (accept && (req_cmd == CMD_RUN)) begin
         tn_in  = TAP_FIRST;
         tm_in  = TAP_FIRST;
         col_in = '0;
         row_in = '0;
      end else if (issue_en) begin
         if (tn_ff != TAP_LAST) begin
            tn_in = tn_ff + TAP_W'(1);
         end else begin
            tn_in = TAP_FIRST;
            if (tm_ff != TAP_LAST) begin
               tm_in = tm_ff + TAP_W'(1);
            end else begin
               tm_in = TAP_FIRST;
               if (!col_end) begin
                  col_in = col_ff + COL_W'(1);
               end else begin
                  col_in = '0;
                  row_in = row_end ? '0 : (row_ff + ROW_W'(1));
               end
            end
         end
      end
   end

   // Read source for the next read word.
   always_comb begin
      rd_src_in = rd_src_ff;
      if (issue_en) begin
         if (scale_ff == '0) rd_src_in = RD_SOURCE;
         else rd_src_in = scale_ff[0] ? RD_SMOOTH0 : RD_SMOOTH1;
      end else if (accept && (req_cmd == CMD_READ)) begin
         if (!read_final) rd_src_in = RD_DETAIL;
         else rd_src_in = run_scales_ff[0] ? RD_SMOOTH0 : RD_SMOOTH1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cfg_rows_ff      <= ROWS_RST;
         cfg_cols_ff      <= COLS_RST;
         cfg_scales_ff    <= SCALES_RST;
         results_valid_ff <= 1'b0;
         run_rows_ff      <= RCNT_W'(RST_ROWS);
         run_cols_ff      <= CCNT_W'(RST_COLS);
         run_scales_ff    <= SCNT_W'(RST_SCALES);
         row_o1_ff        <= '0;
         row_o2_ff        <= '0;
         col_o1_ff        <= '0;
         col_o2_ff        <= '0;
         scale_ff         <= '0;
         row_ff           <= '0;
         col_ff           <= '0;
         tm_ff            <= TAP_FIRST;
         tn_ff            <= TAP_FIRST;
         p1_ff            <= '0;
         p2_ff            <= '0;
         fin_ff           <= '0;
         rd_src_ff        <= RD_SOURCE;
         rsp_strobe_ff    <= 1'b0;
         rsp_status_ff    <= STAT_OK;
      end else begin
         state_ff         <= state_in;
         cfg_rows_ff      <= cfg_rows_in;
         cfg_cols_ff      <= cfg_cols_in;
         cfg_scales_ff    <= cfg_scales_in;
         results_valid_ff <= results_valid_in;
         run_rows_ff      <= run_rows_in;
         run_cols_ff      <= run_cols_in;
         run_scales_ff    <= run_scales_in;
         row_o1_ff        <= row_o1_in;
         row_o2_ff        <= row_o2_in;
         col_o1_ff        <= col_o1_in;
         col_o2_ff        <= col_o2_in;
         scale_ff         <= scale_in;
         row_ff           <= row_in;
         col_ff           <= col_in;
         tm_ff            <= tm_in;
         tn_ff            <= tn_in;
         p1_ff            <= p1_in;
         p2_ff            <= p1_ff;
         fin_ff           <= fin_in;
         rd_src_ff        <= rd_src_in;
         rsp_strobe_ff    <= rsp_strobe_in;
         rsp_status_ff    <= rsp_status_in;
      end
   end

   // Payload registers of the tap pipeline and the response.
   always_ff @(posedge clock) begin
      rsp_coef_ff <= rsp_coef_in;
      prod_ff     <= prod_in;
      if (p1_ff.valid && p1_ff.center) center_ff <= rd_word;
      if (p2_ff.valid) acc_ff <= acc_in;
      if (p2_ff.valid && p2_ff.last) fin_sum_ff <= acc_in;
   end

   // Source image: written by loads, read by the first scale.
   always_ff @(posedge clock) begin
      if (src_we) source_mem[{ROW_W'(req_row), COL_W'(req_col)}] <= req_pixel_value;
      src_rd_ff <= source_mem[mem_pix_addr];
   end

   // Smooth planes in ping-pong: even scales write bank 0, odd scales bank 1.
   always_ff @(posedge clock) begin
      if (fin_ff.valid && !fin_ff.scale[0]) smooth0_mem[fin_pix_addr] <= fin_smooth;
      sm0_rd_ff <= smooth0_mem[mem_pix_addr];
   end

   always_ff @(posedge clock) begin
      if (fin_ff.valid && fin_ff.scale[0]) smooth1_mem[fin_pix_addr] <= fin_smooth;
      sm1_rd_ff <= smooth1_mem[mem_pix_addr];
   end

   // Detail planes, one per scale.
   always_ff @(posedge clock) begin
      if (fin_ff.valid) detail_mem[det_waddr] <= fin_detail;
      if (det_re) det_rd_ff <= detail_mem[det_raddr];
   end

endmodule

// ===== hw/rtl/atwd_checker.sv =====
// Port-level checker of the wavelet decomposition block and its bind to the top level.
module atwd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [atwd_pkg::CMD_W-1:0]          req_cmd,
   input logic                                rsp_strobe,
   input logic signed [atwd_pkg::DATA_W-1:0]  rsp_coefficient,
   input logic [atwd_pkg::STATUS_W-1:0]       rsp_status
);
   import atwd_pkg::*;

   // A load transfer answers in the next cycle and leaves the block free.
   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_LOAD)) |=> (rsp_strobe && !busy))
      else $error("load transfer did not answer in the next cycle");

   // A run transfer always occupies the block.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_RUN)) |=> (busy && !rsp_strobe))
      else $error("run transfer did not raise busy");

   // A read transfer either answers at once with an error or holds the block.
   a_read_follow: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_READ)) |=> (busy || rsp_strobe))
      else $error("read transfer neither answered nor held the block");

   // An error result carries a zero coefficient.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_OK)) |-> (rsp_coefficient == '0))
      else $error("error result carries a coefficient");

   // No result appears without a transfer or work in progress.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start))
      else $error("result strobe without a command");

endmodule

bind a_trous_wavelet_decompose_top atwd_checker u_atwd_checker (.*);
